// ----- src/lsf_pkg.sv -----
// Shared types, constants and helpers for the least-squares line fit unit.
package lsf_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_BITS = 24;
  localparam int CNT_W      = 13;
  localparam int SX_W       = 36;
  localparam int SXX_W      = 59;
  localparam int SXY_W      = 60;
  localparam int PROD_W     = 48;
  localparam int SW         = 100;
  localparam int WW         = 176;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;
  localparam int QUO_W      = 48;
  localparam int CORR_QW    = 31;
  localparam int ROOT_W     = 16;
  localparam int BIT_W      = 6;
  localparam int FRAC_SH    = 16;
  localparam int CORR_SH    = 30;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SX_W-1:0]  sum_x;
    logic [SXX_W-1:0]        sum_xx;
    logic signed [SXY_W-1:0] sum_xy;
    logic signed [SX_W-1:0]  sum_y;
    logic [SXX_W-1:0]        sum_yy;
    logic                    dropped;
  } sums_t;

  typedef struct packed {
    logic             empty;
    logic [FIFO_AW:0] level;
  } fifo_stat_t;

  typedef struct packed {
    logic [QUO_W-1:0]  slope;
    logic [QUO_W-1:0]  intercept;
    logic [ROOT_W-1:0] correlation;
    logic              singular;
    logic              overflowed;
    logic [CNT_W-1:0]  point_count;
  } result_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MSTART = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_DSTART = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_SQRT   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  typedef enum logic [3:0] {
    STEP_N_SXX   = 4'd0,
    STEP_SX_SX   = 4'd1,
    STEP_N_SXY   = 4'd2,
    STEP_SX_SY   = 4'd3,
    STEP_SY_SXX  = 4'd4,
    STEP_SX_SXY  = 4'd5,
    STEP_N_SYY   = 4'd6,
    STEP_SY_SY   = 4'd7,
    STEP_D_E     = 4'd8,
    STEP_NUM_NUM = 4'd9
  } step_e;

  typedef enum logic [1:0] {
    DOP_SLOPE = 2'd0,
    DOP_ICPT  = 2'd1,
    DOP_CORR  = 2'd2
  } div_op_e;

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    mag = v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  function automatic logic [QUO_W-1:0] sat_q(input logic [QUO_W-1:0] q, input logic neg,
                                             input logic big);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mq;
    lim = neg ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
    mq = (big || (q > lim)) ? lim : q;
    sat_q = neg ? QUO_W'(-mq) : mq;
  endfunction

endpackage

// ----- src/lsf_front.sv -----
// Front end: point intake, drop check, product stage and running sums.
module lsf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [23:0]          x_i,
  input  logic [23:0]          y_i,
  input  logic                 last_i,
  input  lsf_pkg::fifo_stat_t  fifo_stat_i,
  output logic                 push_o,
  output lsf_pkg::sums_t       push_data_o
);

  logic signed [23:0] x_s, y_s;
  logic signed [lsf_pkg::PROD_W-1:0] xx_p, xy_p, yy_p;
  logic accept, use_pt, pend;
  logic [lsf_pkg::FIFO_AW+1:0] occ;

  logic [lsf_pkg::CNT_W-1:0] count_q, count_d;
  logic drop_q, drop_d;

  logic v1_q, last1_q, drop1_q;
  logic [lsf_pkg::CNT_W-1:0] cnt1_q;
  logic signed [23:0] x1_q, y1_q;
  logic signed [lsf_pkg::PROD_W-1:0] xx1_q, xy1_q, yy1_q;

  logic signed [lsf_pkg::SX_W-1:0]  sx_q, sx_n, sy_q, sy_n;
  logic [lsf_pkg::SXX_W-1:0]        sxx_q, sxx_n, syy_q, syy_n;
  logic signed [lsf_pkg::SXY_W-1:0] sxy_q, sxy_n;

  assign x_s = 24'(signed'(x_i[lsf_pkg::COORD_BITS-1:0]));
  assign y_s = 24'(signed'(y_i[lsf_pkg::COORD_BITS-1:0]));
  assign xx_p = x_s * x_s;
  assign xy_p = x_s * y_s;
  assign yy_p = y_s * y_s;

  assign pend = v1_q & last1_q;
  assign occ = {1'b0, fifo_stat_i.level} + (lsf_pkg::FIFO_AW+2)'(pend);
  assign ready_o = occ < (lsf_pkg::FIFO_AW+2)'(lsf_pkg::FIFO_DEPTH);
  assign accept = valid_i & ready_o;
  assign use_pt = count_q < lsf_pkg::CNT_W'(lsf_pkg::MAX_POINTS);

  always_comb begin
    count_d = count_q;
    drop_d = drop_q;
    if (accept) begin
      if (last_i) begin
        count_d = '0;
        drop_d = 1'b0;
      end else begin
        count_d = use_pt ? count_q + 1'b1 : count_q;
        drop_d = drop_q | ~use_pt;
      end
    end
  end

  always_comb begin
    sx_n = sx_q;
    sy_n = sy_q;
    sxx_n = sxx_q;
    syy_n = syy_q;
    sxy_n = sxy_q;
    if (v1_q) begin
      sx_n = sx_q + lsf_pkg::SX_W'(x1_q);
      sy_n = sy_q + lsf_pkg::SX_W'(y1_q);
      sxx_n = sxx_q + lsf_pkg::SXX_W'(unsigned'(xx1_q));
      syy_n = syy_q + lsf_pkg::SXX_W'(unsigned'(yy1_q));
      sxy_n = sxy_q + lsf_pkg::SXY_W'(xy1_q);
    end
  end

  assign push_o = pend;
  always_comb begin
    push_data_o.count = cnt1_q;
    push_data_o.sum_x = sx_n;
    push_data_o.sum_xx = sxx_n;
    push_data_o.sum_xy = sxy_n;
    push_data_o.sum_y = sy_n;
    push_data_o.sum_yy = syy_n;
    push_data_o.dropped = drop1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q <= 1'b0;
      v1_q <= 1'b0;
      sx_q <= '0;
      sy_q <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
    end else begin
      count_q <= count_d;
      drop_q <= drop_d;
      v1_q <= accept;
      if (pend) begin
        sx_q <= '0;
        sy_q <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
      end else begin
        sx_q <= sx_n;
        sy_q <= sy_n;
        sxx_q <= sxx_n;
        syy_q <= syy_n;
        sxy_q <= sxy_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last1_q <= last_i;
      cnt1_q <= use_pt ? count_q + 1'b1 : count_q;
      drop1_q <= drop_q | ~use_pt;
      x1_q <= use_pt ? x_s : '0;
      y1_q <= use_pt ? y_s : '0;
      xx1_q <= use_pt ? xx_p : '0;
      xy1_q <= use_pt ? xy_p : '0;
      yy1_q <= use_pt ? yy_p : '0;
    end
  end

endmodule

// ----- src/lsf_fifo.sv -----
// Short queue of finished point sets between the front and back ends.
module lsf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lsf_pkg::sums_t      data_i,
  input  logic                pop_i,
  output lsf_pkg::sums_t      data_o,
  output lsf_pkg::fifo_stat_t stat_o
);

  lsf_pkg::sums_t mem_q [lsf_pkg::FIFO_DEPTH];
  logic [lsf_pkg::FIFO_AW-1:0] wr_q, rd_q;
  logic [lsf_pkg::FIFO_AW:0] level_q;
  logic do_pop;

  assign do_pop = pop_i & (level_q != '0);
  assign data_o = mem_q[rd_q];
  assign stat_o.empty = (level_q == '0);
  assign stat_o.level = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == lsf_pkg::FIFO_AW'(lsf_pkg::FIFO_DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == lsf_pkg::FIFO_AW'(lsf_pkg::FIFO_DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      level_q <= level_q + (lsf_pkg::FIFO_AW+1)'(push_i) - (lsf_pkg::FIFO_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- src/lsf_back.sv -----
// Back end: shift-add products, restoring divisions, square root and result register.
module lsf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsf_pkg::fifo_stat_t fifo_stat_i,
  input  lsf_pkg::sums_t      head_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                ready_i,
  output lsf_pkg::result_t    res_o
);

  localparam int SW = lsf_pkg::SW;
  localparam int WW = lsf_pkg::WW;

  lsf_pkg::state_e state_q, state_d;
  lsf_pkg::step_e step_q, step_d;
  lsf_pkg::div_op_e dop_q, dop_d;
  lsf_pkg::sums_t snap_q, snap_d;

  logic [WW-1:0] acc_q, acc_d, mcand_q, mcand_d, mres;
  logic [SW-1:0] mplier_q, mplier_d;
  logic msign_q, msign_d;
  logic signed [SW-1:0] t_q, t_d, d_q, d_d, num_q, num_d, bnum_q, bnum_d, e_q, e_d, diff;
  logic signed [SW-1:0] opa, opb;
  logic [WW-1:0] p_q, p_d, r_q, r_d;
  logic [WW-1:0] rem_q, rem_d, dsh_q, dsh_d, dvd, dvs;
  logic [lsf_pkg::QUO_W-1:0] quo_q, quo_d, quo_n;
  logic [lsf_pkg::BIT_W-1:0] bit_q, bit_d;
  logic neg_q, neg_d, big_q, big_d, ge;
  logic [lsf_pkg::CORR_QW-1:0] sqv_q, sqv_d;
  logic [lsf_pkg::ROOT_W-1:0] root_q, root_d, cand, root_n;
  logic [2*lsf_pkg::ROOT_W-1:0] sq;
  logic [lsf_pkg::QUO_W-1:0] slope_q, slope_d, icpt_q, icpt_d;
  logic [lsf_pkg::ROOT_W-1:0] corr_q, corr_d;
  logic sing_q, sing_d;

  always_comb begin
    opa = '0;
    opb = '0;
    case (step_q)
      lsf_pkg::STEP_N_SXX: begin
        opa = SW'(snap_q.count);
        opb = SW'(snap_q.sum_xx);
      end
      lsf_pkg::STEP_SX_SX: begin
        opa = SW'(snap_q.sum_x);
        opb = SW'(snap_q.sum_x);
      end
      lsf_pkg::STEP_N_SXY: begin
        opa = SW'(snap_q.count);
        opb = SW'(snap_q.sum_xy);
      end
      lsf_pkg::STEP_SX_SY: begin
        opa = SW'(snap_q.sum_x);
        opb = SW'(snap_q.sum_y);
      end
      lsf_pkg::STEP_SY_SXX: begin
        opa = SW'(snap_q.sum_y);
        opb = SW'(snap_q.sum_xx);
      end
      lsf_pkg::STEP_SX_SXY: begin
        opa = SW'(snap_q.sum_x);
        opb = SW'(snap_q.sum_xy);
      end
      lsf_pkg::STEP_N_SYY: begin
        opa = SW'(snap_q.count);
        opb = SW'(snap_q.sum_yy);
      end
      lsf_pkg::STEP_SY_SY: begin
        opa = SW'(snap_q.sum_y);
        opb = SW'(snap_q.sum_y);
      end
      lsf_pkg::STEP_D_E: begin
        opa = d_q;
        opb = e_q;
      end
      lsf_pkg::STEP_NUM_NUM: begin
        opa = num_q;
        opb = num_q;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mres = msign_q ? WW'(-acc_q) : acc_q;
  assign diff = t_q - SW'(mres);
  assign ge = rem_q >= dsh_q;
  assign quo_n = {quo_q[lsf_pkg::QUO_W-2:0], ge};
  assign cand = root_q | (lsf_pkg::ROOT_W'(1) << bit_q[3:0]);
  assign sq = cand * cand;
  assign root_n = ({1'b0, sqv_q} >= sq) ? cand : root_q;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    dop_d = dop_q;
    snap_d = snap_q;
    acc_d = acc_q;
    mcand_d = mcand_q;
    mplier_d = mplier_q;
    msign_d = msign_q;
    t_d = t_q;
    d_d = d_q;
    num_d = num_q;
    bnum_d = bnum_q;
    e_d = e_q;
    p_d = p_q;
    r_d = r_q;
    rem_d = rem_q;
    dsh_d = dsh_q;
    quo_d = quo_q;
    bit_d = bit_q;
    neg_d = neg_q;
    big_d = big_q;
    sqv_d = sqv_q;
    root_d = root_q;
    slope_d = slope_q;
    icpt_d = icpt_q;
    corr_d = corr_q;
    sing_d = sing_q;
    pop_o = 1'b0;
    dvd = '0;
    dvs = '0;
    case (state_q)
      lsf_pkg::S_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop_o = 1'b1;
          snap_d = head_i;
          step_d = lsf_pkg::STEP_N_SXX;
          slope_d = '0;
          icpt_d = '0;
          corr_d = '0;
          sing_d = 1'b0;
          state_d = lsf_pkg::S_MSTART;
        end
      end
      lsf_pkg::S_MSTART: begin
        mcand_d = WW'(lsf_pkg::mag(opa));
        mplier_d = lsf_pkg::mag(opb);
        msign_d = opa[SW-1] ^ opb[SW-1];
        acc_d = '0;
        state_d = lsf_pkg::S_MUL;
      end
      lsf_pkg::S_MUL: begin
        if (mplier_q == '0) begin
          step_d = lsf_pkg::step_e'(step_q + 1'b1);
          state_d = lsf_pkg::S_MSTART;
          case (step_q)
            lsf_pkg::STEP_N_SXX, lsf_pkg::STEP_N_SXY, lsf_pkg::STEP_SY_SXX,
            lsf_pkg::STEP_N_SYY: begin
              t_d = SW'(mres);
            end
            lsf_pkg::STEP_SX_SX: begin
              d_d = diff;
              if (diff == '0) begin
                sing_d = 1'b1;
                state_d = lsf_pkg::S_OUT;
              end
            end
            lsf_pkg::STEP_SX_SY: begin
              num_d = diff;
            end
            lsf_pkg::STEP_SX_SXY: begin
              bnum_d = diff;
            end
            lsf_pkg::STEP_SY_SY: begin
              e_d = diff;
              if (diff == '0) begin
                dop_d = lsf_pkg::DOP_SLOPE;
                state_d = lsf_pkg::S_DSTART;
              end
            end
            lsf_pkg::STEP_D_E: begin
              p_d = acc_q;
            end
            lsf_pkg::STEP_NUM_NUM: begin
              r_d = acc_q;
              dop_d = lsf_pkg::DOP_SLOPE;
              state_d = lsf_pkg::S_DSTART;
            end
            default: begin
              state_d = lsf_pkg::S_IDLE;
            end
          endcase
        end else begin
          acc_d = mplier_q[0] ? acc_q + mcand_q : acc_q;
          mcand_d = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end
      end
      lsf_pkg::S_DSTART: begin
        quo_d = '0;
        state_d = lsf_pkg::S_DIV;
        case (dop_q)
          lsf_pkg::DOP_SLOPE, lsf_pkg::DOP_ICPT: begin
            dvd = (dop_q == lsf_pkg::DOP_SLOPE) ? WW'(lsf_pkg::mag(num_q)) << lsf_pkg::FRAC_SH
                                                : WW'(lsf_pkg::mag(bnum_q)) << lsf_pkg::FRAC_SH;
            neg_d = (dop_q == lsf_pkg::DOP_SLOPE) ? num_q[SW-1] : bnum_q[SW-1];
            dvs = WW'(d_q);
            rem_d = dvd;
            dsh_d = dvs << (lsf_pkg::QUO_W-1);
            big_d = dvd >= (dvs << lsf_pkg::QUO_W);
            bit_d = lsf_pkg::BIT_W'(lsf_pkg::QUO_W-1);
          end
          lsf_pkg::DOP_CORR: begin
            dvd = r_q << lsf_pkg::CORR_SH;
            dvs = p_q;
            rem_d = dvd;
            dsh_d = dvs << (lsf_pkg::CORR_QW-1);
            big_d = 1'b0;
            neg_d = num_q[SW-1];
            bit_d = lsf_pkg::BIT_W'(lsf_pkg::CORR_QW-1);
          end
          default: begin
            state_d = lsf_pkg::S_IDLE;
          end
        endcase
      end
      lsf_pkg::S_DIV: begin
        if (ge) begin
          rem_d = rem_q - dsh_q;
        end
        quo_d = quo_n;
        dsh_d = dsh_q >> 1;
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          case (dop_q)
            lsf_pkg::DOP_SLOPE: begin
              slope_d = lsf_pkg::sat_q(quo_n, neg_q, big_q);
              dop_d = lsf_pkg::DOP_ICPT;
              state_d = lsf_pkg::S_DSTART;
            end
            lsf_pkg::DOP_ICPT: begin
              icpt_d = lsf_pkg::sat_q(quo_n, neg_q, big_q);
              dop_d = lsf_pkg::DOP_CORR;
              state_d = (e_q == '0) ? lsf_pkg::S_OUT : lsf_pkg::S_DSTART;
            end
            lsf_pkg::DOP_CORR: begin
              sqv_d = quo_n[lsf_pkg::CORR_QW-1:0];
              root_d = '0;
              bit_d = lsf_pkg::BIT_W'(lsf_pkg::ROOT_W-1);
              state_d = lsf_pkg::S_SQRT;
            end
            default: begin
              state_d = lsf_pkg::S_IDLE;
            end
          endcase
        end
      end
      lsf_pkg::S_SQRT: begin
        root_d = root_n;
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          if (neg_q) begin
            corr_d = lsf_pkg::ROOT_W'(-root_n);
          end else begin
            corr_d = root_n[lsf_pkg::ROOT_W-1] ? {1'b0, {(lsf_pkg::ROOT_W-1){1'b1}}} : root_n;
          end
          state_d = lsf_pkg::S_OUT;
        end
      end
      lsf_pkg::S_OUT: begin
        if (ready_i) begin
          state_d = lsf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lsf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsf_pkg::S_IDLE;
      step_q <= lsf_pkg::STEP_N_SXX;
      dop_q <= lsf_pkg::DOP_SLOPE;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      dop_q <= dop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    acc_q <= acc_d;
    mcand_q <= mcand_d;
    mplier_q <= mplier_d;
    msign_q <= msign_d;
    t_q <= t_d;
    d_q <= d_d;
    num_q <= num_d;
    bnum_q <= bnum_d;
    e_q <= e_d;
    p_q <= p_d;
    r_q <= r_d;
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    bit_q <= bit_d;
    neg_q <= neg_d;
    big_q <= big_d;
    sqv_q <= sqv_d;
    root_q <= root_d;
    slope_q <= slope_d;
    icpt_q <= icpt_d;
    corr_q <= corr_d;
    sing_q <= sing_d;
  end

  assign valid_o = (state_q == lsf_pkg::S_OUT);
  always_comb begin
    res_o.slope = slope_q;
    res_o.intercept = icpt_q;
    res_o.correlation = corr_q;
    res_o.singular = sing_q;
    res_o.overflowed = snap_q.dropped;
    res_o.point_count = snap_q.count;
  end

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.singular) |->
    (res_o.slope == '0 && res_o.intercept == '0 && res_o.correlation == '0))
    else $error("singular result carries nonzero fit");

  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsf_pkg::S_IDLE && !fifo_stat_i.empty) |=> (state_q == lsf_pkg::S_MSTART))
    else $error("queued set not taken up");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.point_count <= lsf_pkg::CNT_W'(lsf_pkg::MAX_POINTS)))
    else $error("point count beyond set limit");

endmodule

// ----- src/least_squares_line_fit_unit.sv -----
// Top level of the least-squares line fit unit: stream ports around front, queue and back.
// Points: one beat per cycle while s_axis_tready is high; each is registered, then summed.
// Fit per set, at most: ten shift-add products (one multiplier bit per cycle), two 48-step
// and one 31-step restoring divisions and a 16-step root; two sets may queue.
// Reset (rst_ni low, asynchronous) clears the sums, count, drop flag, queue and sequencer.
module least_squares_line_fit_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lsf_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // x_value, y_value
  input  logic                                s_axis_tlast,  // is_last
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lsf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // slope, intercept, correlation, point_count
  output logic [lsf_pkg::OUT_USER_W-1:0]      m_axis_tuser   // singular, overflowed
);

  logic push, pop;
  lsf_pkg::sums_t push_data, head;
  lsf_pkg::fifo_stat_t fstat;
  lsf_pkg::result_t res;

  lsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .x_i         (s_axis_tdata[23:0]),
    .y_i         (s_axis_tdata[47:24]),
    .last_i      (s_axis_tlast),
    .fifo_stat_i (fstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  lsf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (head),
    .stat_o (fstat)
  );

  lsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fstat),
    .head_i      (head),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.point_count, res.correlation, res.intercept, res.slope};
  assign m_axis_tuser = {res.overflowed, res.singular};

endmodule
